[design/urtq_pkg.sv]
// Package for the UART byte queues: command codes, queue handshake structs,
// default depths and stream widths. No dependencies.
`default_nettype none

package urtq_pkg;

	// Default queue depths (entries, one slot always kept empty)
	localparam int unsigned RX_DEPTH_DEF = 16;
	localparam int unsigned TX_DEPTH_DEF = 128;

	// Field and stream widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned OUT_W   = 88;
	localparam int unsigned OUT_USED_W = 84;

	// Command codes
	typedef enum logic [2:0] {
		CMD_RECV  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READY = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	// Requests from the command decoder to one queue
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_req_t;

	// Status of one queue, from its pointers
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[design/urtq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; storage has no reset.
`default_nettype none

module urtq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds last data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/urtq_queue.sv]
// One circular byte queue: read/write pointers around a urtq_ram instance.
// Depends on urtq_pkg and urtq_ram.
`default_nettype none

module urtq_queue #(
	parameter int unsigned DEPTH = urtq_pkg::RX_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire urtq_pkg::q_req_t               req,
	input  wire logic [urtq_pkg::BYTE_W-1:0]    wdata,
	output urtq_pkg::q_status_t                 status,
	output logic      [urtq_pkg::BYTE_W-1:0]    rdata
);

	import urtq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wr_pos_q;
	logic [AW-1:0] rd_pos_q;
	logic [AW-1:0] wr_nxt;
	logic [AW-1:0] rd_nxt;
	logic          push_ok;
	logic          pop_ok;

	// pointer advance with wrap at the depth
	assign wr_nxt = (wr_pos_q == LAST) ? '0 : wr_pos_q + 1'b1;
	assign rd_nxt = (rd_pos_q == LAST) ? '0 : rd_pos_q + 1'b1;

	// one slot kept empty tells full from empty
	assign status.full  = (wr_nxt == rd_pos_q);
	assign status.empty = (wr_pos_q == rd_pos_q);

	assign push_ok = req.push & ~status.full;
	assign pop_ok  = req.pop & ~status.empty;

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			rd_pos_q <= '0;
		end else if (req.clear) begin
			wr_pos_q <= '0;
			rd_pos_q <= '0;
		end else begin
			if (push_ok) begin
				wr_pos_q <= wr_nxt;
			end
			if (pop_ok) begin
				rd_pos_q <= rd_nxt;
			end
		end
	end

	// entry store; read data is valid the cycle after a pop
	urtq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wr_pos_q),
		.wdata (wdata),
		.re    (pop_ok),
		.raddr (rd_pos_q),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

[design/uart_rx_tx_byte_queues.sv]
// UART receive and transmit byte queues with event counters and tx enable.
// A result beat passes the RAM read and stage 1 registers, then the output register.
// One command per cycle while the result side keeps up; m_tready low stalls s_tready.
// Reset (arst_n low): pointers, counters, tx enable and valids cleared; RAM contents undefined.
// Depends on urtq_pkg and urtq_queue.
`default_nettype none

module uart_rx_tx_byte_queues #(
	parameter int unsigned RX_DEPTH = urtq_pkg::RX_DEPTH_DEF,
	parameter int unsigned TX_DEPTH = urtq_pkg::TX_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [2:0] cmd, [10:3] data_byte, [15:11] zero
	input  wire logic [urtq_pkg::IN_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [7:0] read_byte, [8] read_valid, [9] write_ok, [17:10] send_byte,
	// [18] send_valid, [19] tx_irq_on, [51:20] rx_total, [83:52] tx_total, [87:84] zero
	output logic      [urtq_pkg::OUT_W-1:0]   m_tdata
);

	import urtq_pkg::*;

	logic              acc;
	logic              adv;
	cmd_t              cmd;
	logic [BYTE_W-1:0] data_byte;

	q_req_t            rx_req;
	q_req_t            tx_req;
	q_status_t         rx_st;
	q_status_t         tx_st;
	logic [BYTE_W-1:0] rx_rdata;
	logic [BYTE_W-1:0] tx_rdata;

	logic              irq_q;
	logic [CNT_W-1:0]  rx_cnt_q;
	logic [CNT_W-1:0]  tx_cnt_q;
	logic              irq_d;
	logic [CNT_W-1:0]  rx_cnt_d;
	logic [CNT_W-1:0]  tx_cnt_d;

	logic              s1_valid_q;
	logic              rd_hit_s1;
	logic              snd_hit_s1;
	logic              wok_s1;
	logic              irq_s1;
	logic [CNT_W-1:0]  rx_cnt_s1;
	logic [CNT_W-1:0]  tx_cnt_s1;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [OUT_W-1:0]  result;

	// handshake: stage 1 moves on when the output register is free or drained
	assign adv      = s1_valid_q & (~out_valid_q | m_tready);
	assign s_tready = ~s1_valid_q | adv;
	assign acc      = s_tvalid & s_tready;

	assign cmd       = cmd_t'(s_tdata[2:0]);
	assign data_byte = s_tdata[10:3];

	// command decode into queue requests
	always_comb begin
		rx_req = '0;
		tx_req = '0;
		if (acc) begin
			unique case (cmd)
				CMD_RECV:  rx_req.push = 1'b1;
				CMD_READ:  rx_req.pop  = 1'b1;
				CMD_WRITE: tx_req.push = 1'b1;
				CMD_READY: tx_req.pop  = 1'b1;
				CMD_CLEAR: begin
					rx_req.clear = 1'b1;
					tx_req.clear = 1'b1;
				end
				default: ;
			endcase
		end
	end

	urtq_queue #(
		.DEPTH (RX_DEPTH)
	) u_rx_q (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rx_req),
		.wdata  (data_byte),
		.status (rx_st),
		.rdata  (rx_rdata)
	);

	urtq_queue #(
		.DEPTH (TX_DEPTH)
	) u_tx_q (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tx_req),
		.wdata  (data_byte),
		.status (tx_st),
		.rdata  (tx_rdata)
	);

	// next enable and counters
	always_comb begin
		irq_d    = irq_q;
		rx_cnt_d = rx_cnt_q;
		tx_cnt_d = tx_cnt_q;
		if (rx_req.clear) begin
			irq_d    = 1'b0;
			rx_cnt_d = '0;
			tx_cnt_d = '0;
		end else begin
			if (rx_req.push) begin
				rx_cnt_d = rx_cnt_q + 1'b1;
			end
			if (tx_req.push && !tx_st.full) begin
				irq_d = 1'b1;
			end
			if (tx_req.pop) begin
				tx_cnt_d = tx_cnt_q + 1'b1;
				if (tx_st.empty) begin
					irq_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q    <= 1'b0;
			rx_cnt_q <= '0;
			tx_cnt_q <= '0;
		end else begin
			irq_q    <= irq_d;
			rx_cnt_q <= rx_cnt_d;
			tx_cnt_q <= tx_cnt_d;
		end
	end

	// stage 1: result flags and state snapshot while RAM read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_hit_s1  <= rx_req.pop & ~rx_st.empty;
			snd_hit_s1 <= tx_req.pop & ~tx_st.empty;
			wok_s1     <= tx_req.push & ~tx_st.full;
			irq_s1     <= irq_d;
			rx_cnt_s1  <= rx_cnt_d;
			tx_cnt_s1  <= tx_cnt_d;
		end
	end

	// result beat assembly
	assign result = {
		(OUT_W - OUT_USED_W)'(0),
		tx_cnt_s1,
		rx_cnt_s1,
		irq_s1,
		snd_hit_s1,
		snd_hit_s1 ? tx_rdata : BYTE_W'(0),
		wok_s1,
		rd_hit_s1,
		rd_hit_s1 ? rx_rdata : BYTE_W'(0)
	};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a single command never both reads rx and hands out a tx byte
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> !(rd_hit_s1 && snd_hit_s1))
		else $error("read and send both flagged in one result");

	// a queue is never seen full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_st.full && rx_st.empty) && !(tx_st.full && tx_st.empty))
		else $error("queue full and empty together");

	// clear zeroes counters and enable
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_CLEAR) |=> (rx_cnt_q == '0 && tx_cnt_q == '0 && !irq_q))
		else $error("clear did not reset counters and enable");

	// a stored tx write leaves the enable on
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && wok_s1) |-> irq_s1)
		else $error("tx write stored without enable");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for uart_rx_tx_byte_queues: directed beats, then random command bursts,
// with random stalls on both streams, checked against an in-bench queue predictor or typed expected rows.
// Depends on urtq_pkg and the design sources.
`default_nettype none

module testbench;
	import urtq_pkg::*;

	// Command codes the block ignores
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam int ITEMS       = 750;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;

	// Predictor store index widths
	localparam int RX_AW = $clog2(RX_DEPTH_DEF);
	localparam int TX_AW = $clog2(TX_DEPTH_DEF);

	// Result beat, last field in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]  tx_total;
		logic [CNT_W-1:0]  rx_total;
		logic              tx_irq_on;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
		logic              write_ok;
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
	} result_t;

	typedef struct {
		logic [2:0]        cmd;
		logic [BYTE_W-1:0] data;
		bit                typed;
		result_t           res;
	} row_t;

	typedef enum {MIX_RX_FILL, MIX_RX_DRAIN, MIX_TX_FILL, MIX_TX_DRAIN, MIX_ANY} mix_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// Predictor state
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH_DEF];
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH_DEF];
	int unsigned       rx_wr, rx_rd, tx_wr, tx_rd;
	logic              irq_en;
	logic [CNT_W-1:0]  rx_cnt, tx_cnt;

	// Bookkeeping
	row_t    plan [$];
	result_t pending [$];
	int      beats_in     = 0;
	int      results_seen = 0;
	int      fail_count   = 0;
	int      n_rx_drop = 0, n_tx_full = 0, n_read_empty = 0, n_ready_empty = 0, n_clear = 0;

	uart_rx_tx_byte_queues DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned wrap_inc(int unsigned pos, int unsigned depth);
		return (pos + 1 == depth) ? 0 : pos + 1;
	endfunction

	// One command through both queues; returns the result beat it should produce
	function automatic result_t uart_queue_step(logic [2:0] cmd, logic [BYTE_W-1:0] data);
		result_t r;
		int unsigned nxt;
		r = '0;
		case (cmd)
			CMD_RECV: begin
				nxt = wrap_inc(rx_wr, RX_DEPTH_DEF);
				if (nxt != rx_rd) begin
					rx_mem[RX_AW'(rx_wr)] = data;
					rx_wr = nxt;
				end else begin
					n_rx_drop++;
				end
				rx_cnt = rx_cnt + 1;
			end
			CMD_READ: begin
				if (rx_rd != rx_wr) begin
					r.read_byte  = rx_mem[RX_AW'(rx_rd)];
					r.read_valid = 1'b1;
					rx_rd = wrap_inc(rx_rd, RX_DEPTH_DEF);
				end else begin
					n_read_empty++;
				end
			end
			CMD_WRITE: begin
				nxt = wrap_inc(tx_wr, TX_DEPTH_DEF);
				if (nxt != tx_rd) begin
					tx_mem[TX_AW'(tx_wr)] = data;
					tx_wr = nxt;
					irq_en = 1'b1;
					r.write_ok = 1'b1;
				end else begin
					n_tx_full++;
				end
			end
			CMD_READY: begin
				if (tx_rd != tx_wr) begin
					r.send_byte  = tx_mem[TX_AW'(tx_rd)];
					r.send_valid = 1'b1;
					tx_rd = wrap_inc(tx_rd, TX_DEPTH_DEF);
				end else begin
					irq_en = 1'b0;
					n_ready_empty++;
				end
				tx_cnt = tx_cnt + 1;
			end
			CMD_CLEAR: begin
				rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
				irq_en = 1'b0;
				rx_cnt = '0; tx_cnt = '0;
				n_clear++;
			end
			default: ;
		endcase
		r.tx_irq_on = irq_en;
		r.rx_total  = rx_cnt;
		r.tx_total  = tx_cnt;
		return r;
	endfunction

	function automatic result_t exp_res(logic [7:0] rb, logic rv, logic wo, logic [7:0] sb,
			logic sv, logic irq, logic [31:0] rxt, logic [31:0] txt);
		result_t r;
		r.read_byte = rb; r.read_valid = rv; r.write_ok = wo;
		r.send_byte = sb; r.send_valid = sv; r.tx_irq_on = irq;
		r.rx_total = rxt; r.tx_total = txt;
		return r;
	endfunction

	task automatic add_row(logic [2:0] cmd, logic [7:0] data, bit typed, result_t res);
		row_t row;
		row.cmd = cmd; row.data = data; row.typed = typed; row.res = res;
		plan.push_back(row);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			fail_count++;
		end
	endtask

	// Mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [2:0] pick_cmd(mix_t mix);
		int r;
		r = $urandom_range(0, 199);
		if (r == 0 && mix != MIX_TX_FILL)
			return CMD_CLEAR;
		if (r < 5)
			return 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
		r = $urandom_range(0, 99);
		case (mix)
			MIX_RX_FILL:  return (r < 80) ? CMD_RECV : CMD_READ;
			MIX_RX_DRAIN: return (r < 80) ? CMD_READ : CMD_RECV;
			MIX_TX_FILL:  return (r < 85) ? CMD_WRITE : CMD_READY;
			MIX_TX_DRAIN: return (r < 85) ? CMD_READY : CMD_WRITE;
			default:      return 3'($urandom_range(CMD_RECV, CMD_READY));
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'h00;
		if (r < 20)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Present one command beat and hold it until accepted
	task automatic offer(logic [2:0] cmd, logic [7:0] data);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - 3 - BYTE_W){1'b0}}, data, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Scoreboard: predict on each command beat, check each result beat
	always @(posedge clk) begin
		result_t want, seen;
		if (arst_n && s_tvalid && s_tready) begin
			want = uart_queue_step(s_tdata[2:0], s_tdata[3 +: BYTE_W]);
			if (beats_in < plan.size() && plan[beats_in].typed)
				want = plan[beats_in].res;
			pending.push_back(want);
			beats_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			seen = m_tdata[OUT_USED_W-1:0];
			if (pending.size() == 0) begin
				$error("result beat with no command waiting: 0x%0h", m_tdata);
				fail_count++;
			end else begin
				want = pending.pop_front();
				check_field("read_byte",  32'(want.read_byte),  32'(seen.read_byte));
				check_field("read_valid", 32'(want.read_valid), 32'(seen.read_valid));
				check_field("write_ok",   32'(want.write_ok),   32'(seen.write_ok));
				check_field("send_byte",  32'(want.send_byte),  32'(seen.send_byte));
				check_field("send_valid", 32'(want.send_valid), 32'(seen.send_valid));
				check_field("tx_irq_on",  32'(want.tx_irq_on),  32'(seen.tx_irq_on));
				check_field("rx_total",   want.rx_total,   seen.rx_total);
				check_field("tx_total",   want.tx_total,   seen.tx_total);
				check_field("pad", '0, 32'(m_tdata[OUT_W-1:OUT_USED_W]));
			end
		end
	end

	// Result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall_left, tick;
		bit rx_quiet, held;
		stall_left = 0; tick = 0; rx_quiet = 0; held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 100 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			if (!held && results_seen >= 200) begin
				held = 1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = rx_quiet ? 0 : pick_gap();
			end
		end
	end

	// Watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		int idle;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle = 0;
		else
			idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", idle);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus
	initial begin
		mix_t mix;
		int len, k, gap, work_sent;
		bit tx_quiet, drained_mid;
		logic [2:0] c;
		logic [7:0] d;

		rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
		irq_en = 1'b0; rx_cnt = '0; tx_cnt = '0;
		work_sent = 0; drained_mid = 0;

		// Directed: empty reads and ready events, byte extremes, ignored codes, clear
		add_row(CMD_READ,  8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
		add_row(CMD_READY, 8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 0, 1));
		add_row(CMD_RECV,  8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 1, 1));
		add_row(CMD_RECV,  8'hFF, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 2, 1));
		add_row(CMD_READ,  8'h00, 1, exp_res(8'h00, 1, 0, 8'h00, 0, 0, 2, 1));
		add_row(CMD_READ,  8'h00, 1, exp_res(8'hFF, 1, 0, 8'h00, 0, 0, 2, 1));
		add_row(CMD_READ,  8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 2, 1));
		add_row(CMD_WRITE, 8'hFF, 1, exp_res(8'h00, 0, 1, 8'h00, 0, 1, 2, 1));
		add_row(CMD_WRITE, 8'h00, 1, exp_res(8'h00, 0, 1, 8'h00, 0, 1, 2, 1));
		add_row(CMD_READY, 8'h00, 1, exp_res(8'h00, 0, 0, 8'hFF, 1, 1, 2, 2));
		add_row(CMD_READY, 8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 1, 1, 2, 3));
		add_row(CMD_READY, 8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 2, 4));
		add_row(CMD_RSVD5, 8'hAA, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 2, 4));
		add_row(CMD_RSVD6, 8'h55, 0, '0);
		add_row(CMD_RSVD7, 8'hFF, 0, '0);
		add_row(CMD_WRITE, 8'h5A, 0, '0);
		add_row(CMD_RECV,  8'hAA, 0, '0);
		add_row(CMD_CLEAR, 8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
		// stored bytes stay behind a clear but are no longer queued
		add_row(CMD_READY, 8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 0, 1));
		add_row(CMD_READY, 8'h00, 0, '0);
		add_row(CMD_READ,  8'h00, 1, exp_res(8'h00, 0, 0, 8'h00, 0, 0, 0, 2));
		add_row(CMD_RECV,  8'h55, 0, '0);
		add_row(CMD_READ,  8'h00, 0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			offer(plan[i].cmd, plan[i].data);
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end

		// Random bursts aimed at filling and draining each queue
		while (work_sent < ITEMS) begin
			mix = mix_t'($urandom_range(0, 4));
			len = (mix == MIX_TX_FILL) ? $urandom_range(40, 180) : $urandom_range(5, 40);
			tx_quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < len && work_sent < ITEMS; k++) begin
				c = pick_cmd(mix);
				d = pick_byte();
				offer(c, d);
				if (c <= CMD_CLEAR)
					work_sent++;
				if (!drained_mid && work_sent >= ITEMS / 2) begin
					// stop and let every outstanding result come back
					drained_mid = 1;
					@(negedge clk);
					s_tvalid <= 1'b0;
					while (pending.size() != 0) @(posedge clk);
				end else begin
					gap = tx_quiet ? 0 : pick_gap();
					if (gap > 0) begin
						@(negedge clk);
						s_tvalid <= 1'b0;
						repeat (gap - 1) @(negedge clk);
					end
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d command beats and %0d result beats under random stalls.",
			beats_in, results_seen);
		$display("Seen: %0d rx drops, %0d refused tx writes, %0d empty reads,",
			n_rx_drop, n_tx_full, n_read_empty);
		$display("      %0d empty ready, %0d clears.", n_ready_empty, n_clear);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
